// ===== rtl/ttcc_pkg.sv =====
package ttcc_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_CONTROL_MODE    = 3'd0;
    localparam logic [2:0] REG_DIR_SPEED_LIMIT = 3'd1;
    localparam logic [2:0] REG_DIR_SPEED_HYST  = 3'd2;
    localparam logic [2:0] REG_CUR_MAX         = 3'd3;
    localparam logic [2:0] REG_CUR_MIN         = 3'd4;
    localparam logic [2:0] REG_SS_ENABLE       = 3'd5;
    localparam logic [2:0] REG_SS_BRAKE        = 3'd6;

    // control modes
    localparam logic [1:0] MODE_CURRENT   = 2'd0;
    localparam logic [1:0] MODE_BRAKE_NEG = 2'd1;
    localparam logic [1:0] MODE_HYST_REV  = 2'd2;

    // command kinds
    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_DRIVE    = 2'd1;
    localparam logic [1:0] KIND_BRAKE    = 2'd2;
    localparam logic [1:0] KIND_SS_BRAKE = 2'd3;

    // idle tracker stages
    localparam logic [1:0] IDLE_RUN     = 2'd0;
    localparam logic [1:0] IDLE_BRAKING = 2'd1;
    localparam logic [1:0] IDLE_REVERSE = 2'd2;

    // current clamp in milliamps
    localparam int CUR_LIMIT = 500000;

    typedef struct packed {
        logic [1:0]         mode;
        logic [17:0]        speed_limit;
        logic [15:0]        speed_hyst;
        logic [18:0]        cur_max;
        logic signed [19:0] cur_min;
        logic               ss_enable;
        logic [18:0]        ss_brake;
    } t_cfg;

    typedef struct packed {
        logic       brake_lock;
        logic [1:0] idle_stage;
    } t_m2_state;

    typedef struct packed {
        logic               brake;
        logic signed [19:0] cur;
        t_m2_state          m2_next;
    } t_decision;

endpackage

// ===== rtl/ttcc_in_if.sv =====
interface ttcc_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] throttle;
    logic signed [31:0] motor_speed;
    logic               fault_or_timeout;

    modport source (output valid, output throttle, output motor_speed,
                    output fault_or_timeout, input ready);
    modport sink (input valid, input throttle, input motor_speed,
                  input fault_or_timeout, output ready);
endinterface

// ===== rtl/ttcc_out_if.sv =====
interface ttcc_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command_kind;
    logic signed [19:0] current_ma;

    modport source (output valid, output command_kind, output current_ma, input ready);
    modport sink (input valid, input command_kind, input current_ma, output ready);
endinterface

// ===== rtl/ttcc_core.sv =====
module ttcc_core (
    input  logic signed [15:0]  i_throttle,
    input  logic signed [31:0]  i_motor_speed,
    input  ttcc_pkg::t_cfg      i_cfg,
    input  ttcc_pkg::t_m2_state i_m2,
    output ttcc_pkg::t_decision o_dec
);
    import ttcc_pkg::*;

    logic signed [16:0] t_ext;
    logic signed [16:0] t_abs;
    logic signed [20:0] max_ext;
    logic signed [20:0] min_ext;
    logic signed [20:0] min_mag;
    logic signed [33:0] spd;
    logic signed [33:0] lim;
    logic signed [33:0] hyst;
    logic signed [33:0] lim_lo;
    logic signed [33:0] lim_hi;
    logic signed [33:0] lim_neg;
    logic               t_neg;
    logic               t_zero;
    logic               fb1;
    logic [1:0]         idle1;
    t_m2_state          m2_next;
    logic               brake;
    logic signed [16:0] mul_a;
    logic signed [20:0] mul_b;
    logic signed [37:0] prod;
    logic signed [37:0] prod_bias;
    logic signed [22:0] quot;
    logic signed [19:0] cur;

    // operand magnitudes
    assign t_ext   = {i_throttle[15], i_throttle};
    assign t_abs   = i_throttle[15] ? -t_ext : t_ext;
    assign t_neg   = i_throttle[15];
    assign t_zero  = (i_throttle == 16'sd0);
    assign max_ext = {2'b00, i_cfg.cur_max};
    assign min_ext = {i_cfg.cur_min[19], i_cfg.cur_min};
    assign min_mag = i_cfg.cur_min[19] ? -min_ext : min_ext;

    // speed thresholds
    assign spd     = {{2{i_motor_speed[31]}}, i_motor_speed};
    assign lim     = {16'd0, i_cfg.speed_limit};
    assign hyst    = {18'd0, i_cfg.speed_hyst};
    assign lim_lo  = lim - hyst;
    assign lim_hi  = lim + hyst;
    assign lim_neg = -lim;

    // speed hysteresis on the brake-lock flag
    always_comb begin
        fb1   = i_m2.brake_lock;
        idle1 = i_m2.idle_stage;
        if (i_m2.brake_lock) begin
            if (spd < lim_lo) begin
                fb1   = 1'b0;
                idle1 = IDLE_RUN;
            end
        end else begin
            if (spd > lim_hi) begin
                fb1   = 1'b1;
                idle1 = IDLE_RUN;
            end
        end
    end

    // mode decision and multiplier operand selection
    always_comb begin
        m2_next.brake_lock = fb1;
        m2_next.idle_stage = idle1;
        brake              = 1'b0;
        mul_a              = t_ext;
        mul_b              = max_ext;
        case (i_cfg.mode)
            MODE_CURRENT: begin
                if ((!t_neg && spd > 34'sd0) || (t_neg && spd < 34'sd0)) begin
                    mul_b = max_ext;
                end else begin
                    mul_b = min_mag;
                end
            end
            MODE_BRAKE_NEG: begin
                brake = t_neg;
                if (!t_neg && spd > 34'sd0) begin
                    mul_b = max_ext;
                end else begin
                    mul_a = t_abs;
                    mul_b = min_mag;
                end
            end
            MODE_HYST_REV: begin
                if (!t_neg) begin
                    if (t_zero) begin
                        if (idle1 == IDLE_BRAKING && !fb1) begin
                            m2_next.idle_stage = IDLE_REVERSE;
                        end
                    end else if (spd > lim_neg) begin
                        m2_next.idle_stage = IDLE_RUN;
                    end
                    mul_b = max_ext;
                end else begin
                    if (fb1) begin
                        brake = 1'b1;
                    end else if (spd > lim_neg) begin
                        if (idle1 != IDLE_REVERSE) begin
                            m2_next.idle_stage = IDLE_BRAKING;
                            brake              = 1'b1;
                        end
                    end else begin
                        if (idle1 == IDLE_BRAKING) begin
                            brake = 1'b1;
                        end else begin
                            m2_next.idle_stage = IDLE_REVERSE;
                        end
                    end
                    mul_a = brake ? t_abs : t_ext;
                    mul_b = min_mag;
                end
            end
            default: begin
                brake = 1'b0;
            end
        endcase
    end

    // scale by limit, Q1.15, rounded toward zero, then clamp
    assign prod      = mul_a * mul_b;
    assign prod_bias = prod + (prod[37] ? 38'sd32767 : 38'sd0);
    assign quot      = prod_bias[37:15];

    always_comb begin
        if (quot > 23'(CUR_LIMIT)) begin
            cur = 20'(CUR_LIMIT);
        end else if (quot < -23'(CUR_LIMIT)) begin
            cur = -20'(CUR_LIMIT);
        end else begin
            cur = quot[19:0];
        end
    end

    assign o_dec.brake   = brake;
    assign o_dec.cur     = cur;
    assign o_dec.m2_next = m2_next;

endmodule

// ===== rtl/throttle_to_current_command_top.sv =====
// Throttle to motor current command, one command per control tick.
// Input channel i_in carries a Q1.15 throttle, the signed motor speed in
// electrical rpm and a fault/timeout flag; output channel o_out carries the
// command kind (none, drive, brake, safe-start brake) and the current in mA.
// Both channels use a valid/ready handshake; a beat moves on valid && ready.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data; the
// user must write it only while the block is idle, which the block does not
// enforce; any write to a defined register restarts safe start. The result
// of a beat in the input register enters the output register when that is
// empty or being taken. Throughput: one beat per cycle unless o_out stalls;
// a single 17x21 multiply and compares lie between input and output registers.
// When o_out is stalled the output register holds its result, the input
// register may still take one more beat, and i_in.ready then drops until the
// output is taken.
// Reset (i_rst_n low, synchronous) loads the register defaults, forces the
// brake flag, clears the idle tracker and the safe-start counters and empties
// both pipeline registers.
module throttle_to_current_command_top #(
    parameter int SAFE_START_TICKS = 50,
    parameter int ZERO_BAND        = 33
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data,
    ttcc_in_if.sink     i_in,
    ttcc_out_if.source  o_out
);
    import ttcc_pkg::*;

    localparam int CntW = $clog2(SAFE_START_TICKS + 1);

    t_cfg               r_cfg;
    t_m2_state          r_m2;
    t_m2_state          n_m2;
    logic [CntW-1:0]    r_cnt;
    logic [CntW-1:0]    n_cnt;
    logic [CntW-1:0]    r_cnt_prev;
    logic [CntW-1:0]    n_cnt_prev;
    logic [CntW-1:0]    cnt_inc;
    logic               r_in_valid;
    logic signed [15:0] r_throttle;
    logic signed [31:0] r_speed;
    logic               r_fault;
    logic               r_out_valid;
    logic [1:0]         r_out_kind;
    logic [1:0]         n_out_kind;
    logic signed [19:0] r_out_cur;
    logic signed [19:0] n_out_cur;
    logic               advance;
    logic               cfg_hit;
    logic signed [16:0] t_ext;
    logic signed [16:0] t_abs;
    logic               zero_tick;
    logic signed [19:0] ss_cur;
    t_decision          dec;

    // handshake
    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign o_out.valid = r_out_valid;
    assign o_out.command_kind = r_out_kind;
    assign o_out.current_ma   = r_out_cur;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode        <= MODE_CURRENT;
            r_cfg.speed_limit <= 18'd2500;
            r_cfg.speed_hyst  <= 16'd500;
            r_cfg.cur_max     <= 19'd60000;
            r_cfg.cur_min     <= -20'sd60000;
            r_cfg.ss_enable   <= 1'b1;
            r_cfg.ss_brake    <= 19'd3000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CONTROL_MODE:    r_cfg.mode        <= i_cfg_data[1:0];
                REG_DIR_SPEED_LIMIT: r_cfg.speed_limit <= i_cfg_data[17:0];
                REG_DIR_SPEED_HYST:  r_cfg.speed_hyst  <= i_cfg_data[15:0];
                REG_CUR_MAX:         r_cfg.cur_max     <= i_cfg_data[18:0];
                REG_CUR_MIN:         r_cfg.cur_min     <= i_cfg_data;
                REG_SS_ENABLE:       r_cfg.ss_enable   <= i_cfg_data[0];
                REG_SS_BRAKE:        r_cfg.ss_brake    <= i_cfg_data[18:0];
                default:             r_cfg             <= r_cfg;
            endcase
        end
    end

    assign cfg_hit = i_cfg_we && (i_cfg_index <= REG_SS_BRAKE);

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_throttle <= i_in.throttle;
            r_speed    <= i_in.motor_speed;
            r_fault    <= i_in.fault_or_timeout;
        end
    end

    ttcc_core u_core (
        .i_throttle    (r_throttle),
        .i_motor_speed (r_speed),
        .i_cfg         (r_cfg),
        .i_m2          (r_m2),
        .o_dec         (dec)
    );

    // zero-throttle detect and safe-start brake clamp
    assign t_ext     = {r_throttle[15], r_throttle};
    assign t_abs     = r_throttle[15] ? -t_ext : t_ext;
    assign zero_tick = (t_abs < 17'(ZERO_BAND));
    assign cnt_inc   = (zero_tick && (r_cnt < CntW'(SAFE_START_TICKS))) ?
                       r_cnt + CntW'(1) : r_cnt;
    assign ss_cur    = ({1'b0, r_cfg.ss_brake} > 20'(CUR_LIMIT)) ?
                       20'(CUR_LIMIT) : {1'b0, r_cfg.ss_brake};

    // command selection, safe start and state update
    always_comb begin
        n_out_kind = KIND_NONE;
        n_out_cur  = 20'sd0;
        n_cnt      = r_cnt;
        n_cnt_prev = r_cnt_prev;
        n_m2       = r_m2;
        if (r_fault) begin
            n_cnt = '0;
        end else if (r_cfg.mode <= MODE_HYST_REV) begin
            if (r_cfg.mode == MODE_HYST_REV) begin
                n_m2 = dec.m2_next;
            end
            if ((cnt_inc < CntW'(SAFE_START_TICKS)) && r_cfg.ss_enable) begin
                n_cnt      = (cnt_inc == r_cnt_prev) ? '0 : cnt_inc;
                n_cnt_prev = n_cnt;
                n_out_kind = KIND_SS_BRAKE;
                n_out_cur  = ss_cur;
            end else begin
                n_cnt      = cnt_inc;
                n_out_kind = dec.brake ? KIND_BRAKE : KIND_DRIVE;
                n_out_cur  = dec.cur;
            end
        end
    end

    // tick state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2.brake_lock <= 1'b1;
            r_m2.idle_stage <= IDLE_RUN;
            r_cnt           <= '0;
            r_cnt_prev      <= '0;
        end else if (cfg_hit) begin
            r_cnt <= '0;
        end else if (advance) begin
            r_m2       <= n_m2;
            r_cnt      <= n_cnt;
            r_cnt_prev <= n_cnt_prev;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_kind <= n_out_kind;
            r_out_cur  <= n_out_cur;
        end
    end

endmodule

// ===== tb/ttcc_checker.sv =====
module ttcc_checker #(
    parameter int SAFE_START_TICKS = 50,
    parameter int ZERO_BAND        = 33
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data,
    ttcc_in_if          i_tick,
    ttcc_out_if         i_cmd,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    import ttcc_pkg::*;

    localparam int MAX_PRINTS = 30;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [19:0] cur;
    } t_command;

    // predicted configuration and controller state
    t_cfg       cfg;
    t_m2_state  m2;
    logic [5:0] zero_cnt;
    logic [5:0] zero_cnt_prev;

    t_command expected_cmds[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    task automatic report_mismatch(input string msg);
        if (o_fail_count < MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    function automatic longint mag_of(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint clamp_cur(input longint v);
        if (v > CUR_LIMIT) return CUR_LIMIT;
        if (v < -CUR_LIMIT) return -CUR_LIMIT;
        return v;
    endfunction

    // throttle times limit over 2^15, truncated toward zero
    function automatic longint scale_cur(input longint t, input longint mag);
        longint p;
        p = t * mag;
        if (p >= 0) return clamp_cur(p >>> 15);
        return clamp_cur(-((-p) >>> 15));
    endfunction

    task automatic reset_model();
        cfg.mode          = MODE_CURRENT;
        cfg.speed_limit   = 18'd2500;
        cfg.speed_hyst    = 16'd500;
        cfg.cur_max       = 19'd60000;
        cfg.cur_min       = -20'sd60000;
        cfg.ss_enable     = 1'b1;
        cfg.ss_brake      = 19'd3000;
        m2.brake_lock     = 1'b1;
        m2.idle_stage     = IDLE_RUN;
        zero_cnt          = '0;
        zero_cnt_prev     = '0;
    endtask

    // any defined register write restarts safe start
    task automatic apply_register(input logic [2:0] idx, input logic [19:0] data);
        logic known;
        known = 1'b1;
        case (idx)
            REG_CONTROL_MODE:    cfg.mode        = data[1:0];
            REG_DIR_SPEED_LIMIT: cfg.speed_limit = data[17:0];
            REG_DIR_SPEED_HYST:  cfg.speed_hyst  = data[15:0];
            REG_CUR_MAX:         cfg.cur_max     = data[18:0];
            REG_CUR_MIN:         cfg.cur_min     = data;
            REG_SS_ENABLE:       cfg.ss_enable   = data[0];
            REG_SS_BRAKE:        cfg.ss_brake    = data[18:0];
            default:             known           = 1'b0;
        endcase
        if (known) zero_cnt = '0;
    endtask

    task automatic predict_command(input logic signed [15:0] thr,
                                   input logic signed [31:0] speed,
                                   input logic flt,
                                   output t_command cmd);
        longint t, spd, lim, hyst, maxc, minmag, cur;
        logic   brake;
        t      = thr;
        spd    = speed;
        lim    = cfg.speed_limit;
        hyst   = cfg.speed_hyst;
        maxc   = cfg.cur_max;
        minmag = mag_of(longint'($signed(cfg.cur_min)));
        cur    = 0;
        brake  = 1'b0;
        cmd.kind = KIND_NONE;

        if (flt) begin
            zero_cnt = '0;
        end else if (cfg.mode <= MODE_HYST_REV) begin
            if (cfg.mode == MODE_CURRENT) begin
                if ((t >= 0 && spd > 0) || (t < 0 && spd < 0))
                    cur = scale_cur(t, maxc);
                else
                    cur = scale_cur(t, minmag);
            end else if (cfg.mode == MODE_BRAKE_NEG) begin
                brake = (t < 0);
                if (t >= 0 && spd > 0)
                    cur = scale_cur(t, maxc);
                else
                    cur = scale_cur(mag_of(t), minmag);
            end else begin
                // speed hysteresis on the brake-lock flag
                if (m2.brake_lock) begin
                    if (spd < lim - hyst) begin
                        m2.brake_lock = 1'b0;
                        m2.idle_stage = IDLE_RUN;
                    end
                end else if (spd > lim + hyst) begin
                    m2.brake_lock = 1'b1;
                    m2.idle_stage = IDLE_RUN;
                end
                // idle tracker decides brake versus reverse
                if (t >= 0) begin
                    if (t == 0) begin
                        if (m2.idle_stage == IDLE_BRAKING && !m2.brake_lock)
                            m2.idle_stage = IDLE_REVERSE;
                    end else if (spd > -lim) begin
                        m2.idle_stage = IDLE_RUN;
                    end
                    cur = scale_cur(t, maxc);
                end else begin
                    if (m2.brake_lock) begin
                        brake = 1'b1;
                    end else if (spd > -lim) begin
                        if (m2.idle_stage != IDLE_REVERSE) begin
                            m2.idle_stage = IDLE_BRAKING;
                            brake = 1'b1;
                        end
                    end else if (m2.idle_stage == IDLE_BRAKING) begin
                        brake = 1'b1;
                    end else begin
                        m2.idle_stage = IDLE_REVERSE;
                    end
                    cur = brake ? scale_cur(mag_of(t), minmag) : scale_cur(t, minmag);
                end
            end

            // zero tick counting, saturating
            if (mag_of(t) < ZERO_BAND && zero_cnt < SAFE_START_TICKS)
                zero_cnt = zero_cnt + 6'd1;

            if (zero_cnt < SAFE_START_TICKS && cfg.ss_enable) begin
                if (zero_cnt == zero_cnt_prev) zero_cnt = '0;
                zero_cnt_prev = zero_cnt;
                cmd.kind = KIND_SS_BRAKE;
                cur = clamp_cur(longint'(cfg.ss_brake));
            end else begin
                cmd.kind = brake ? KIND_BRAKE : KIND_DRIVE;
            end
        end
        cmd.cur = cur[19:0];
    endtask

    // compare finished beats first, then predict the new one
    always @(posedge i_clk) begin : watch_channels
        t_command want;
        if (!i_rst_n) begin
            reset_model();
            expected_cmds.delete();
        end else begin
            if (i_cmd.valid && i_cmd.ready) begin
                if (expected_cmds.size() == 0) begin
                    report_mismatch($sformatf("unexpected command kind %0d current %0d",
                                              i_cmd.command_kind, i_cmd.current_ma));
                end else begin
                    want = expected_cmds.pop_front();
                    if (i_cmd.command_kind !== want.kind)
                        report_mismatch($sformatf("command_kind %0d, expected %0d",
                                                  i_cmd.command_kind, want.kind));
                    if (i_cmd.current_ma !== want.cur)
                        report_mismatch($sformatf("current_ma %0d, expected %0d",
                                                  i_cmd.current_ma, want.cur));
                    o_checked++;
                end
            end
            if (i_cfg_we) apply_register(i_cfg_index, i_cfg_data);
            if (i_tick.valid && i_tick.ready) begin
                predict_command(i_tick.throttle, i_tick.motor_speed,
                                i_tick.fault_or_timeout, want);
                expected_cmds.push_back(want);
            end
        end
        o_pending = expected_cmds.size();
    end

endmodule

// ===== tb/tb.sv =====
module tb;
    import ttcc_pkg::*;

    localparam int         SAFE_TICKS  = 50;
    localparam int         ZERO_BAND   = 33;
    localparam int         NUM_PHASES  = 10;
    localparam int         STALL_LIMIT = 2000;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [2:0] REG_UNUSED  = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [19:0] i_cfg_data;

    int fail_count, pending, checked;
    int quiet_cycles = 0;
    int idle_pct  = 0;
    int stall_pct = 0;
    int ticks_sent = 0;

    // mirrors of the register values that shape the stimulus
    int spd_lim  = 2500;
    int spd_hyst = 500;
    bit ss_on    = 1'b1;

    ttcc_in_if  tick_ch ();
    ttcc_out_if cmd_ch ();

    throttle_to_current_command_top #(
        .SAFE_START_TICKS (SAFE_TICKS),
        .ZERO_BAND        (ZERO_BAND)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (tick_ch),
        .o_out       (cmd_ch)
    );

    ttcc_checker #(
        .SAFE_START_TICKS (SAFE_TICKS),
        .ZERO_BAND        (ZERO_BAND)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_tick       (tick_ch),
        .i_cmd        (cmd_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #6 i_clk = ~i_clk;

    // command receiver with random back-pressure
    always @(negedge i_clk) begin
        cmd_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // watchdog on cycles with no beat and no register write
    always @(posedge i_clk) begin
        if ((tick_ch.valid && tick_ch.ready) || (cmd_ch.valid && cmd_ch.ready) ||
            i_cfg_we || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_tick(input logic signed [15:0] thr, input logic signed [31:0] spd,
                             input logic flt);
        while ($urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            tick_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        tick_ch.valid            <= 1'b1;
        tick_ch.throttle         <= thr;
        tick_ch.motor_speed      <= spd;
        tick_ch.fault_or_timeout <= flt;
        do @(posedge i_clk); while (!tick_ch.ready);
        ticks_sent++;
    endtask

    // stop sending and let every pending command drain
    task automatic drain_ticks();
        @(negedge i_clk);
        tick_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [19:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_DIR_SPEED_LIMIT: spd_lim  = int'(data[17:0]);
            REG_DIR_SPEED_HYST:  spd_hyst = int'(data[15:0]);
            REG_SS_ENABLE:       ss_on    = data[0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [1:0] mode, input int lim, input int hyst,
                             input int cmax, input int cmin, input bit ss, input int ss_brk);
        write_reg(REG_CONTROL_MODE, 20'(mode));
        write_reg(REG_DIR_SPEED_LIMIT, 20'(lim));
        write_reg(REG_DIR_SPEED_HYST, 20'(hyst));
        write_reg(REG_CUR_MAX, 20'(cmax));
        write_reg(REG_CUR_MIN, 20'(cmin));
        write_reg(REG_SS_ENABLE, 20'(ss));
        write_reg(REG_SS_BRAKE, 20'(ss_brk));
    endtask

    task automatic setup_phase(input int ph);
        case (ph)
            0: write_all(MODE_CURRENT, 2500, 500, 60000, -60000, 1'b1, 3000);
            1: write_all(MODE_BRAKE_NEG, 2500, 500, 500000, -500000, 1'b1, 500000);
            2: write_all(MODE_HYST_REV, 2500, 500, 60000, -60000, 1'b1, 3000);
            3: write_all(MODE_HYST_REV, 0, 0, 60000, -60000, 1'b0, 3000);
            4: write_all(MODE_HYST_REV, 200000, 40000, 0, 0, 1'b1, 0);
            5: write_all(MODE_CURRENT, 1000, 200, 524287, -524288, 1'b1, 524287);
            6: begin
                write_reg(REG_CONTROL_MODE, 20'(MODE_UNUSED));
                write_reg(REG_UNUSED, 20'hfffff);
            end
            7: write_all(MODE_HYST_REV, 262143, 65535, 524287, -1, 1'b0, 1);
            8: write_all(MODE_BRAKE_NEG, $urandom_range(0, 200000), $urandom_range(0, 40000),
                         $urandom_range(0, 500000), -int'($urandom_range(0, 500000)),
                         1'b0, $urandom_range(0, 500000));
            default: write_all(MODE_HYST_REV, $urandom_range(0, 200000),
                               $urandom_range(0, 40000), $urandom_range(0, 500000),
                               -int'($urandom_range(0, 500000)), 1'b1,
                               $urandom_range(0, 500000));
        endcase
    endtask

    function automatic logic signed [15:0] zero_band_throttle();
        return 16'(int'($urandom_range(0, 2 * ZERO_BAND - 2)) - (ZERO_BAND - 1));
    endfunction

    function automatic logic signed [15:0] pick_throttle();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 2) return zero_band_throttle();
        if (sel == 2) begin
            case ($urandom_range(0, 5))
                0: return -16'sd32768;
                1: return 16'sd32767;
                2: return 16'sd0;
                3: return 16'(ZERO_BAND);
                4: return 16'(-ZERO_BAND);
                default: return -16'sd1;
            endcase
        end
        return 16'($urandom);
    endfunction

    // speeds clustered on the hysteresis and reverse thresholds
    function automatic logic signed [31:0] pick_speed();
        int unsigned sel;
        int center, jitter, span;
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
            case ($urandom_range(0, 5))
                0: center = spd_lim - spd_hyst;
                1: center = spd_lim + spd_hyst;
                2: center = -spd_lim;
                3: center = spd_lim;
                4: center = 0;
                default: center = -(spd_lim + spd_hyst);
            endcase
            jitter = ($urandom_range(0, 1) == 1) ? int'($urandom_range(0, 6)) - 3
                                                 : int'($urandom_range(0, 600)) - 300;
            return center + jitter;
        end
        if (sel < 7) begin
            span = spd_lim + spd_hyst + 1000;
            return int'($urandom_range(0, 2 * span)) - span;
        end
        if (sel == 7) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'sd1;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    initial begin
        int len, count, target;
        i_rst_n                  = 1'b0;
        i_cfg_we                 = 1'b0;
        i_cfg_index              = '0;
        i_cfg_data               = '0;
        tick_ch.valid            = 1'b0;
        tick_ch.throttle         = '0;
        tick_ch.motor_speed      = '0;
        tick_ch.fault_or_timeout = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // safe start at reset defaults: hold, zero ticks, band edges, break, fault
        send_tick(16'sd1000, 32'sd500, 1'b0);
        send_tick(16'sd0, 32'sd500, 1'b0);
        send_tick(-16'sd32, 32'sd500, 1'b0);
        send_tick(16'sd32, 32'sd500, 1'b0);
        send_tick(16'sd33, 32'sd500, 1'b0);
        send_tick(-16'sd33, 32'sd500, 1'b0);
        send_tick(16'sd0, 32'sd0, 1'b1);
        drain_ticks();
        write_reg(REG_SS_ENABLE, 20'd0);

        // current mode with field extremes and sign combinations
        send_tick(16'sd32767, 32'sh7fff_ffff, 1'b0);
        send_tick(-16'sd32768, 32'sh8000_0000, 1'b0);
        send_tick(16'sd32767, -32'sd1, 1'b0);
        send_tick(-16'sd32768, 32'sd1, 1'b0);
        send_tick(16'sd0, 32'sd0, 1'b0);
        send_tick(-16'sd1, 32'sd0, 1'b0);
        send_tick(16'sd1, 32'sd1, 1'b0);
        send_tick(16'sd32767, 32'sd0, 1'b0);
        send_tick(-16'sd32768, 32'sh8000_0000, 1'b1);
        drain_ticks();
        write_reg(REG_CONTROL_MODE, 20'(MODE_BRAKE_NEG));

        // brake on negative throttle
        send_tick(-16'sd32768, 32'sd100, 1'b0);
        send_tick(16'sd100, 32'sd100, 1'b0);
        send_tick(16'sd100, -32'sd100, 1'b0);
        drain_ticks();
        write_reg(REG_CONTROL_MODE, 20'(MODE_HYST_REV));

        // forced brake, release, idle braking, reverse, force again
        send_tick(-16'sd1000, 32'sd5000, 1'b0);
        send_tick(-16'sd1000, 32'sd0, 1'b0);
        send_tick(16'sd0, 32'sd0, 1'b0);
        send_tick(-16'sd1000, 32'sd0, 1'b0);
        send_tick(-16'sd1000, -32'sd3000, 1'b0);
        send_tick(16'sd1000, 32'sd3100, 1'b0);

        // random phases, each with its own register setting and idle pattern
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_ticks();
            setup_phase(ph);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 47; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 47; end
                default: begin idle_pct = 24; stall_pct = 24; end
            endcase
            target = (ph == 6) ? 60 : 140;
            count = 0;
            while (count < target) begin
                // a run of zero ticks to get past safe start
                if ($urandom_range(0, 99) < (ss_on ? 75 : 20)) begin
                    len = $urandom_range(SAFE_TICKS - 6, SAFE_TICKS + 6);
                    repeat (len) send_tick(zero_band_throttle(), pick_speed(), 1'b0);
                    count += len;
                end
                len = $urandom_range(15, 50);
                repeat (len)
                    send_tick(pick_throttle(), pick_speed(), $urandom_range(0, 99) < 3);
                count += len;
            end
        end

        drain_ticks();
        repeat (4) @(posedge i_clk);
        $display("run covered %0d ticks in %0d register phases, all modes and idle patterns",
                 ticks_sent, NUM_PHASES);
        $display("%0d commands compared, %0d mismatches", checked, fail_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
